[hw/rtl/hrdp_pkg.sv]
package hrdp_pkg;

  localparam int FCNT_W = 7;
  localparam int UCNT_W = 9;

  localparam logic [7:0] LONG_HDR = 8'hFE;
  localparam logic [7:0] MAX_DATA_LEN = 8'd4;

  localparam logic [1:0] TYPE_MAIN   = 2'd0;
  localparam logic [1:0] TYPE_GLOBAL = 2'd1;
  localparam logic [1:0] TYPE_LOCAL  = 2'd2;

  localparam logic [7:0] TAG_PAGE   = 8'd0;
  localparam logic [7:0] TAG_LMIN   = 8'd1;
  localparam logic [7:0] TAG_LMAX   = 8'd2;
  localparam logic [7:0] TAG_PMAX   = 8'd4;
  localparam logic [7:0] TAG_RSIZE  = 8'd7;
  localparam logic [7:0] TAG_RID    = 8'd8;
  localparam logic [7:0] TAG_RCOUNT = 8'd9;
  localparam logic [7:0] TAG_USAGE  = 8'd0;
  localparam logic [7:0] TAG_UMIN   = 8'd1;
  localparam logic [7:0] TAG_UMAX   = 8'd2;
  localparam logic [7:0] TAG_INPUT  = 8'd8;

  localparam logic [15:0] NO_RID       = 16'hFFFF;
  localparam logic [15:0] PAGE_DESKTOP = 16'h0001;
  localparam logic [15:0] PAGE_BUTTON  = 16'h0009;
  localparam logic [15:0] USAGE_AXIS_LO = 16'h0030;
  localparam logic [15:0] USAGE_HAT    = 16'h0039;

  localparam logic [1:0] KIND_OTHER  = 2'd0;
  localparam logic [1:0] KIND_AXIS   = 2'd1;
  localparam logic [1:0] KIND_HAT    = 2'd2;
  localparam logic [1:0] KIND_BUTTON = 2'd3;

  typedef enum logic [1:0] {PH_HEADER, PH_LONG_LEN, PH_LONG_TAG, PH_DATA} phase_t;
  typedef enum logic [1:0] {BK_IDLE, BK_READ, BK_EMIT} bk_state_t;

  typedef struct packed {
    logic [7:0]        rid;
    logic [15:0]       page;
    logic [31:0]       lmin;
    logic [31:0]       lmax;
    logic [5:0]        size;
    logic [15:0]       cursor;
    logic [FCNT_W-1:0] nrec;
    logic [UCNT_W-1:0] ucount;
    logic [31:0]       rmin;
    logic              range_ok;
  } cmd_t;

  function automatic logic [2:0] size_bytes(input logic [1:0] code);
    logic [2:0] r;
    unique case (code)
      2'd0: r = 3'd0;
      2'd1: r = 3'd1;
      2'd2: r = 3'd2;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/hrdp_ram.sv]
module hrdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[hw/rtl/hrdp_front.sv]
module hrdp_front #(
  parameter int MAX_FIELDS = 64,
  parameter int LOCAL_USAGE_DEPTH = 64,
  parameter int AW = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  logic [7:0]      desc_byte,
  input  logic            last_byte,
  output logic            wr_en,
  output logic [AW-1:0]   wr_addr,
  output logic [31:0]     wr_data,
  output logic            push,
  output hrdp_pkg::cmd_t  cmd
);
  import hrdp_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [7:0]        hdr_r, hdr_nxt, len_r, len_nxt, tag_r, tag_nxt;
  logic [2:0]        seen_r, seen_nxt, seen_inc;
  logic [31:0]       acc_r, acc_nxt, v_now;
  logic [15:0]       page_r, page_nxt, rsize_r, rsize_nxt, rcount_r, rcount_nxt;
  logic [15:0]       rid_r, rid_nxt, cursor_r, cursor_nxt;
  logic [31:0]       lmin_r, lmin_nxt, lmax_r, lmax_nxt, rmin_r, rmin_nxt;
  logic [UCNT_W-1:0] ucount_r, ucount_nxt;
  logic [1:0]        rvalid_r, rvalid_nxt;
  logic [FCNT_W-1:0] fe_r, fe_nxt, rem, nrec;
  logic              stop_r, stop_nxt;

  logic        fin;
  logic [7:0]  f_hdr, f_tag, f_len;
  logic [31:0] f_v, fv;
  logic [15:0] size, count, span;
  logic [31:0] prod;

  assign seen_inc = seen_r + 3'd1;
  assign v_now = acc_r | ({24'd0, desc_byte} << {seen_r[1:0], 3'b000});

  always_comb begin
    phase_nxt = phase_r;
    if (acc && !stop_r) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (desc_byte == LONG_HDR) begin
            phase_nxt = PH_LONG_LEN;
          end else if (desc_byte[1:0] != 2'd0) begin
            phase_nxt = PH_DATA;
          end
        end
        PH_LONG_LEN: phase_nxt = PH_LONG_TAG;
        PH_LONG_TAG: begin
          if (len_r == 8'd0 || len_r > MAX_DATA_LEN) begin
            phase_nxt = PH_HEADER;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          if ({5'd0, seen_inc} >= len_r) begin
            phase_nxt = PH_HEADER;
          end
        end
        default: phase_nxt = PH_HEADER;
      endcase
    end
  end

  always_comb begin
    hdr_nxt = hdr_r;
    len_nxt = len_r;
    tag_nxt = tag_r;
    seen_nxt = seen_r;
    acc_nxt = acc_r;
    page_nxt = page_r;
    lmin_nxt = lmin_r;
    lmax_nxt = lmax_r;
    rsize_nxt = rsize_r;
    rcount_nxt = rcount_r;
    rid_nxt = rid_r;
    cursor_nxt = cursor_r;
    ucount_nxt = ucount_r;
    rmin_nxt = rmin_r;
    rvalid_nxt = rvalid_r;
    fe_nxt = fe_r;
    stop_nxt = stop_r;
    fin = 1'b0;
    f_hdr = hdr_r;
    f_tag = tag_r;
    f_len = len_r;
    f_v = v_now;
    wr_en = 1'b0;
    wr_addr = ucount_r[AW-1:0];
    push = 1'b0;
    nrec = '0;

    if (acc && !stop_r) begin
      unique case (phase_r)
        PH_HEADER: begin
          hdr_nxt = desc_byte;
          acc_nxt = '0;
          seen_nxt = '0;
          if (desc_byte != LONG_HDR) begin
            len_nxt = {5'd0, size_bytes(desc_byte[1:0])};
            tag_nxt = {4'd0, desc_byte[7:4]};
            if (desc_byte[1:0] == 2'd0) begin
              fin = 1'b1;
              f_hdr = desc_byte;
              f_tag = {4'd0, desc_byte[7:4]};
              f_len = '0;
              f_v = '0;
            end
          end
        end
        PH_LONG_LEN: len_nxt = desc_byte;
        PH_LONG_TAG: begin
          tag_nxt = desc_byte;
          if (len_r > MAX_DATA_LEN) begin
            stop_nxt = 1'b1;
          end
        end
        PH_DATA: begin
          acc_nxt = v_now;
          seen_nxt = seen_inc;
          if ({5'd0, seen_inc} >= len_r) begin
            fin = 1'b1;
          end
        end
        default: ;
      endcase
    end

    fv = f_v;
    if (f_hdr[3:2] == TYPE_GLOBAL && f_tag >= TAG_LMIN && f_tag <= TAG_PMAX) begin
      if (f_len == 8'd1 && f_v[7]) begin
        fv = f_v | 32'hFFFF_FF00;
      end else if (f_len == 8'd2 && f_v[15]) begin
        fv = f_v | 32'hFFFF_0000;
      end
    end

    size = (rsize_r == 16'd0) ? 16'd8 : rsize_r;
    count = (rcount_r == 16'd0) ? 16'd1 : rcount_r;
    prod = 32'(size) * 32'(count);
    span = prod[15:0];
    rem = FCNT_W'(MAX_FIELDS) - fe_r;

    if (fin) begin
      priority if (f_hdr[3:2] == TYPE_GLOBAL) begin
        if (f_tag == TAG_PAGE) page_nxt = fv[15:0];
        if (f_tag == TAG_LMIN) lmin_nxt = fv;
        if (f_tag == TAG_LMAX) lmax_nxt = fv;
        if (f_tag == TAG_RSIZE) rsize_nxt = fv[15:0];
        if (f_tag == TAG_RCOUNT) rcount_nxt = fv[15:0];
        if (f_tag == TAG_RID && rid_r != fv[15:0]) begin
          rid_nxt = fv[15:0];
          cursor_nxt = '0;
        end
      end else if (f_hdr[3:2] == TYPE_LOCAL) begin
        if (f_tag == TAG_USAGE && ucount_r < UCNT_W'(LOCAL_USAGE_DEPTH)) begin
          wr_en = 1'b1;
          ucount_nxt = ucount_r + 1'b1;
        end
        if (f_tag == TAG_UMIN) begin
          rmin_nxt = fv;
          rvalid_nxt = rvalid_r | 2'b01;
        end
        if (f_tag == TAG_UMAX) rvalid_nxt = rvalid_r | 2'b10;
      end else if (f_hdr[3:2] == TYPE_MAIN) begin
        if (f_tag == TAG_INPUT) begin
          if (fv[0]) begin
            cursor_nxt = cursor_r + span;
          end else if (fv[1] && !count[15] && size <= 16'd32) begin
            nrec = (count < {9'd0, rem}) ? count[FCNT_W-1:0] : rem;
            push = (nrec != '0);
            fe_nxt = fe_r + nrec;
            cursor_nxt = cursor_r + span;
          end
        end
        ucount_nxt = '0;
        rvalid_nxt = '0;
        rmin_nxt = '0;
      end else begin
      end
    end
  end

  assign wr_data = fv;

  always_comb begin
    cmd.rid = (rid_r == NO_RID) ? 8'd0 : rid_r[7:0];
    cmd.page = page_r;
    cmd.lmin = lmin_r;
    cmd.lmax = lmax_r;
    cmd.size = size[5:0];
    cmd.cursor = cursor_r;
    cmd.nrec = nrec;
    cmd.ucount = ucount_r;
    cmd.rmin = rmin_r;
    cmd.range_ok = (rvalid_r == 2'b11);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && last_byte)) begin
      phase_r <= PH_HEADER;
      hdr_r <= '0;
      len_r <= '0;
      tag_r <= '0;
      seen_r <= '0;
      acc_r <= '0;
      page_r <= '0;
      lmin_r <= '0;
      lmax_r <= '0;
      rsize_r <= '0;
      rcount_r <= '0;
      rid_r <= NO_RID;
      cursor_r <= '0;
      ucount_r <= '0;
      rmin_r <= '0;
      rvalid_r <= '0;
      fe_r <= '0;
      stop_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      hdr_r <= hdr_nxt;
      len_r <= len_nxt;
      tag_r <= tag_nxt;
      seen_r <= seen_nxt;
      acc_r <= acc_nxt;
      page_r <= page_nxt;
      lmin_r <= lmin_nxt;
      lmax_r <= lmax_nxt;
      rsize_r <= rsize_nxt;
      rcount_r <= rcount_nxt;
      rid_r <= rid_nxt;
      cursor_r <= cursor_nxt;
      ucount_r <= ucount_nxt;
      rmin_r <= rmin_nxt;
      rvalid_r <= rvalid_nxt;
      fe_r <= fe_nxt;
      stop_r <= stop_nxt;
    end
  end
endmodule

[hw/rtl/hrdp_cmdq.sv]
module hrdp_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hrdp_pkg::cmd_t din,
  input  logic           pop,
  output hrdp_pkg::cmd_t dout,
  output logic           empty,
  output logic           full
);
  import hrdp_pkg::*;

  cmd_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full = (cnt_r == 2'd2);
  assign dout = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wp_r] <= din;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end
endmodule

[hw/rtl/hrdp_back.sv]
module hrdp_back #(
  parameter int AW = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  hrdp_pkg::cmd_t q_dout,
  output logic           q_pop,
  output logic           rd_en,
  output logic [AW-1:0]  rd_addr,
  input  logic [31:0]    rd_data,
  output logic           idle,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_report_ident,
  output logic [15:0]    out_usage_page,
  output logic [15:0]    out_usage_code,
  output logic [15:0]    out_bit_position,
  output logic [5:0]     out_bit_width,
  output logic [31:0]    out_logical_low,
  output logic [31:0]    out_logical_high,
  output logic [1:0]     out_field_kind,
  output logic           out_last_field
);
  import hrdp_pkg::*;

  bk_state_t         state_r, state_nxt;
  cmd_t              cmd_r;
  logic [FCNT_W-1:0] k_r;
  logic [15:0]       pos_r;
  logic              lastrec;
  logic [UCNT_W-1:0] idx;
  logic [31:0]       uv;
  logic [15:0]       page;

  assign lastrec = ((k_r + 1'b1) == cmd_r.nrec);
  assign idx = ({2'd0, k_r} < cmd_r.ucount) ? {2'd0, k_r} : (cmd_r.ucount - 1'b1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!q_empty) state_nxt = BK_READ;
      BK_READ: state_nxt = BK_EMIT;
      BK_EMIT: if (out_ready) state_nxt = lastrec ? BK_IDLE : BK_READ;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state_r == BK_IDLE) && !q_empty;
    idle = (state_r == BK_IDLE);
    rd_en = (state_r == BK_READ);
    rd_addr = idx[AW-1:0];
    out_valid = (state_r == BK_EMIT);
    if (cmd_r.ucount != '0) begin
      uv = rd_data;
    end else if (cmd_r.range_ok) begin
      uv = cmd_r.rmin + {25'd0, k_r};
    end else begin
      uv = '0;
    end
    page = (uv[31:16] == 16'd0) ? cmd_r.page : uv[31:16];
    out_report_ident = cmd_r.rid;
    out_usage_page = page;
    out_usage_code = uv[15:0];
    out_bit_position = pos_r;
    out_bit_width = cmd_r.size;
    out_logical_low = cmd_r.lmin;
    out_logical_high = cmd_r.lmax;
    out_last_field = lastrec;
    out_field_kind = KIND_OTHER;
    if (page == PAGE_DESKTOP) begin
      if (uv[15:0] == USAGE_HAT) begin
        out_field_kind = KIND_HAT;
      end else if (uv[15:0] >= USAGE_AXIS_LO && uv[15:0] < USAGE_HAT) begin
        out_field_kind = KIND_AXIS;
      end
    end else if (page == PAGE_BUTTON) begin
      out_field_kind = KIND_BUTTON;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_dout;
      k_r <= '0;
      pos_r <= q_dout.cursor;
    end else if (state_r == BK_EMIT && out_ready && !lastrec) begin
      k_r <= k_r + 1'b1;
      pos_r <= pos_r + {10'd0, cmd_r.size};
    end
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

[hw/rtl/hid_report_descriptor_parser.sv]
// A byte that completes an Input item pushes a command into the queue; the back end pops it into
// its command register, reads the usage store, then shows the first field record. Throughput: one
// descriptor byte per cycle while no records are pending; each record takes a usage store read,
// then a transfer that waits on out_ready, and bytes wait until all records of the item are out.
// Reset: rst_n low, synchronous; the front end also returns to reset after the last byte.
module hid_report_descriptor_parser #(
  parameter int MAX_FIELDS = 64,
  parameter int LOCAL_USAGE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_desc_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_report_ident,
  output logic [15:0] out_usage_page,
  output logic [15:0] out_usage_code,
  output logic [15:0] out_bit_position,
  output logic [5:0]  out_bit_width,
  output logic [31:0] out_logical_low,
  output logic [31:0] out_logical_high,
  output logic [1:0]  out_field_kind,
  output logic        out_last_field
);
  import hrdp_pkg::*;

  localparam int AW = (LOCAL_USAGE_DEPTH > 1) ? $clog2(LOCAL_USAGE_DEPTH) : 1;

  logic          acc, wr_en, rd_en, q_push, q_pop, q_empty, q_full, back_idle;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   wr_data, rd_data;
  cmd_t          q_din, q_dout;

  assign in_ready = q_empty && back_idle;
  assign acc = in_valid && in_ready;

  hrdp_front #(
    .MAX_FIELDS(MAX_FIELDS),
    .LOCAL_USAGE_DEPTH(LOCAL_USAGE_DEPTH),
    .AW(AW)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .acc(acc),
    .desc_byte(in_desc_byte),
    .last_byte(in_last_byte),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .push(q_push),
    .cmd(q_din)
  );

  hrdp_ram #(
    .WIDTH(32),
    .DEPTH(LOCAL_USAGE_DEPTH)
  ) u_usage_ram (
    .clk(clk),
    .we(wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re(rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  hrdp_cmdq u_cmdq (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .din(q_din),
    .pop(q_pop),
    .dout(q_dout),
    .empty(q_empty),
    .full(q_full)
  );

  hrdp_back #(
    .AW(AW)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_empty(q_empty),
    .q_dout(q_dout),
    .q_pop(q_pop),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .idle(back_idle),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_report_ident(out_report_ident),
    .out_usage_page(out_usage_page),
    .out_usage_code(out_usage_code),
    .out_bit_position(out_bit_position),
    .out_bit_width(out_bit_width),
    .out_logical_low(out_logical_low),
    .out_logical_high(out_logical_high),
    .out_field_kind(out_field_kind),
    .out_last_field(out_last_field)
  );

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("command queue overflow");

  a_push_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> !in_ready) else $error("byte taken while records pending");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_field) |=> in_ready)
    else $error("input not released after last record");
endmodule
